// ===== sv/sm3_hash_engine_macros.svh =====
// assertion macros shared by the sm3 hash engine rtl
// no dependencies
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SM3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same check, also active during reset
`define SM3_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/sm3_pkg.sv =====
// sm3 package: constants, types and round functions for the hash engine
// no dependencies
package sm3_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned BUF_DEPTH = 16;
   localparam int unsigned BUF_AW = 4;
   localparam int unsigned ROUNDS = 64;
   localparam int unsigned DIG_WORDS = 8;

   localparam logic [31:0] T_LOW = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type w;
      case (idx)
         3'd0: w = 32'h7380166F;
         3'd1: w = 32'h4914B2B9;
         3'd2: w = 32'h172442D7;
         3'd3: w = 32'hDA8A0600;
         3'd4: w = 32'hA96F30BC;
         3'd5: w = 32'h163138AA;
         3'd6: w = 32'hE38DEE4D;
         3'd7: w = 32'hB0FB0E4E;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ===== sv/sm3_hash_engine.sv =====
// sm3 hash engine: block buffer memory, expansion window, one round per cycle
// depends on sm3_pkg and sm3_hash_engine_macros.svh
// after a block's 16th word: buffer load into the window, the rounds, then the fold; a last word adds
// padding words, one or two compressions and then the eight digest words
// one shared round unit; new words are taken only in idle, not while a block is compressed
// reset: synchronous, active high; iv reloaded, length and fill clear, memories not cleared
`include "sm3_hash_engine_macros.svh"

module sm3_hash_engine
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // message_word[31:0], word_bytes[34:32], zero
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], digest_index[34:32], zero
   output logic        rsp_tlast    // digest_last
);

   // storage
   word_type buf_mem [BUF_DEPTH];   // block buffer, one write and one read port
   word_type win_mem [BUF_DEPTH];   // rolling expansion window
   word_type cv_ff [DIG_WORDS];
   word_type wr_ff [DIG_WORDS];     // a..h
   word_type buf_rd_ff;

   state_type state_ff, state_in;
   logic [BUF_AW-1:0] fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [6:0] cnt_ff, cnt_in;      // load index or round index
   logic [1:0] pad_ff, pad_in;      // 0 0x80 word, 1 zero fill, 2 len high, 3 len low
   logic fin_ff, fin_in;            // padding pending after this block
   logic [2:0] oi_ff, oi_in;

   // buffer write port
   logic buf_we;
   logic [BUF_AW-1:0] buf_wa;
   word_type buf_wd;

   // last word formatting
   word_type in_word;
   logic [2:0] in_nb;
   word_type last_fmt;
   logic [5:0] sh;

   assign in_word = req_tdata[31:0];
   assign in_nb = (req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];
   assign sh = 6'd32 - {in_nb, 3'b000};

   always_comb begin
      word_type m;
      m = (in_nb == 3'd0) ? 32'h0 : (32'hFFFFFFFF << sh[4:0]);
      last_fmt = (in_word & m) | ({24'h0, PAD_BYTE} << (6'd24 - {in_nb, 3'b000}));
      if (in_nb == 3'd4) last_fmt = in_word;
   end

   // round datapath, window taps come from the register file by fixed offsets
   logic [3:0] j4;
   word_type wj, wj4, wj7, wj13, wj3, wj10, wnext;
   word_type a12, ss1, ss2, ffv, ggv, tt1, tt2, tc;
   logic [5:0] rj;

   assign rj = cnt_ff[5:0];
   assign j4 = rj[3:0];
   assign wj = win_mem[j4];
   assign wj4 = win_mem[j4 + 4'd4];
   assign wj7 = win_mem[j4 + 4'd7];
   assign wj13 = win_mem[j4 + 4'd13];
   assign wj3 = win_mem[j4 + 4'd3];
   assign wj10 = win_mem[j4 + 4'd10];

   always_comb begin
      tc = rotl((rj < 6'd16) ? T_LOW : T_HIGH, rj[4:0]);
      a12 = rotl(wr_ff[0], 5'd12);
      ss1 = rotl(a12 + wr_ff[4] + tc, 5'd7);
      ss2 = ss1 ^ a12;
      if (rj < 6'd16) begin
         ffv = wr_ff[0] ^ wr_ff[1] ^ wr_ff[2];
         ggv = wr_ff[4] ^ wr_ff[5] ^ wr_ff[6];
      end else begin
         ffv = (wr_ff[0] & wr_ff[1]) | (wr_ff[0] & wr_ff[2]) | (wr_ff[1] & wr_ff[2]);
         ggv = (wr_ff[4] & wr_ff[5]) | (~wr_ff[4] & wr_ff[6]);
      end
      tt1 = ffv + wr_ff[3] + ss2 + (wj ^ wj4);
      tt2 = ggv + wr_ff[7] + ss1 + wj;
      wnext = perm1(wj ^ wj7 ^ rotl(wj13, 5'd15)) ^ rotl(wj3, 5'd7) ^ wj10;
   end

   // control
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      pad_in = pad_ff;
      fin_in = fin_ff;
      oi_in = oi_ff;
      buf_we = 1'b0;
      buf_wa = fill_ff;
      buf_wd = in_word;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               buf_we = 1'b1;
               fill_in = fill_ff + 4'd1;
               if (!req_tlast) begin
                  len_in = len_ff + 64'd32;
                  if (fill_ff == 4'd15) begin
                     state_in = ST_LOAD;
                     cnt_in = '0;
                  end
               end else begin
                  len_in = len_ff + {58'd0, in_nb, 3'b000};
                  buf_wd = last_fmt;
                  fin_in = 1'b1;
                  // a full last word needs a separate 0x80 word
                  pad_in = (in_nb == 3'd4) ? 2'd0 : 2'd1;
                  state_in = ST_PAD;
                  if (fill_ff == 4'd15) begin
                     state_in = ST_LOAD;
                     cnt_in = '0;
                  end
               end
            end
         end
         ST_PAD: begin
            // pad 0: write 0x80 word; 1: zeros to 14; 2/3: length words
            buf_we = 1'b1;
            fill_in = fill_ff + 4'd1;
            case (pad_ff)
               2'd0: begin
                  buf_wd = PAD_WORD;
                  pad_in = 2'd1;
               end
               2'd1: begin
                  buf_wd = '0;
                  if (fill_ff == 4'd14) begin
                     buf_we = 1'b0;
                     fill_in = fill_ff;
                     pad_in = 2'd2;
                  end
               end
               2'd2: begin
                  buf_wd = len_ff[63:32];
                  pad_in = 2'd3;
               end
               default: begin
                  buf_wd = len_ff[31:0];
                  fin_in = 1'b0;
               end
            endcase
            if (buf_we && fill_ff == 4'd15) begin
               state_in = ST_LOAD;
               cnt_in = '0;
            end
         end
         ST_LOAD: begin
            // read buffer one word a cycle into the window via a registered read
            buf_wa = fill_ff;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd16) begin
               state_in = ST_ROUND;
               cnt_in = '0;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(ROUNDS - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            fill_in = '0;
            if (fin_ff) state_in = ST_PAD;
            else if (pad_ff == 2'd3) begin
               state_in = ST_OUT;
               oi_in = '0;
            end else state_in = ST_IDLE;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               oi_in = oi_ff + 3'd1;
               if (oi_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  len_in = '0;
                  pad_in = 2'd0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
         pad_ff <= 2'd0;
         fin_ff <= 1'b0;
         oi_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
         fin_ff <= fin_in;
         oi_ff <= oi_in;
      end
   end

   // block buffer memory: synchronous write, registered read
   always_ff @(posedge clock) begin
      if (buf_we) buf_mem[buf_wa] <= buf_wd;
      buf_rd_ff <= buf_mem[cnt_ff[BUF_AW-1:0]];
   end

   // expansion window: loaded from buffer, then one word replaced per round
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && cnt_ff != 7'd0)
         win_mem[4'(cnt_ff - 7'd1)] <= buf_rd_ff;
      else if (state_ff == ST_ROUND)
         win_mem[j4] <= wnext;
   end

   // working registers and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIG_WORDS; i++) cv_ff[i] <= iv_word(3'(i));
      end else if (state_ff == ST_FOLD) begin
         for (int i = 0; i < DIG_WORDS; i++) cv_ff[i] <= cv_ff[i] ^ wr_ff[i];
      end else if (state_ff == ST_OUT && rsp_tready && oi_ff == 3'd7) begin
         for (int i = 0; i < DIG_WORDS; i++) cv_ff[i] <= iv_word(3'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < DIG_WORDS; i++) wr_ff[i] <= cv_ff[i];
      end else if (state_ff == ST_ROUND) begin
         wr_ff[0] <= tt1;
         wr_ff[1] <= wr_ff[0];
         wr_ff[2] <= rotl(wr_ff[1], 5'd9);
         wr_ff[3] <= wr_ff[2];
         wr_ff[4] <= perm0(tt2);
         wr_ff[5] <= wr_ff[4];
         wr_ff[6] <= rotl(wr_ff[5], 5'd19);
         wr_ff[7] <= wr_ff[6];
      end
   end

   // digest output straight from the chaining registers
   assign rsp_tdata = {5'd0, oi_ff, cv_ff[oi_ff]};
   assign rsp_tlast = (oi_ff == 3'd7);

   // checks
   `SM3_ASSERT(a_out_only_when_idle_in, clock, reset, rsp_tvalid |-> !req_tready, "input taken during digest output")
   `SM3_ASSERT(a_round_follows_load, clock, reset, (state_ff == ST_LOAD && cnt_ff == 7'd16) |=> (state_ff == ST_ROUND && cnt_ff == 7'd0), "load did not hand over to rounds")
   `SM3_ASSERT(a_fold_clears_fill, clock, reset, (state_ff == ST_FOLD) |=> (fill_ff == 4'd0), "fill count not cleared after block")
   `SM3_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && fill_ff == 4'd0), "reset did not clear control")

endmodule

// ===== tb/sm3_hash_checker.sv =====
// sm3 hash checker: watches request and response words, predicts digests, compares
// depends on sm3_pkg for the word type, iv, round constants and padding word
`timescale 1ns / 100ps

module sm3_hash_checker
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      word_type   dword;
      logic [2:0] index;
      logic       last;
   } digest_item_type;

   // predictor state
   word_type        chain_q[8];
   word_type        block_q[16];
   int              fill_q;
   logic [63:0]     msg_bits;
   digest_item_type digest_fifo[$];

   assign pending_count = digest_fifo.size();

   function automatic word_type rol(word_type x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic word_type p0f(word_type x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic word_type p1f(word_type x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   // one 64-round compression of the buffered block into the chain value
   task automatic compress_block();
      word_type w[16];
      word_type a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tc, nw;
      w = block_q;
      {a, b, c, d, e, f, g, h} = {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                                  chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
      for (int j = 0; j < 64; j++) begin
         tc  = (j < 16) ? T_LOW : T_HIGH;
         a12 = rol(a, 12);
         ss1 = rol(a12 + e + rol(tc, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
         gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
         tt1 = ff + d + ss2 + (w[j % 16] ^ w[(j + 4) % 16]);
         tt2 = gg + h + ss1 + w[j % 16];
         nw  = p1f(w[j % 16] ^ w[(j + 7) % 16] ^ rol(w[(j + 13) % 16], 15))
               ^ rol(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
         w[j % 16] = nw;
         d = c; c = rol(b, 9); b = a; a = tt1;
         h = g; g = rol(f, 19); f = e; e = p0f(tt2);
      end
      chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
      chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
   endtask

   task automatic push_block_word(word_type w);
      block_q[fill_q] = w;
      fill_q++;
      if (fill_q == 16) begin
         compress_block();
         fill_q = 0;
      end
   endtask

   function automatic void rearm();
      for (int i = 0; i < 8; i++) chain_q[i] = iv_word(3'(i));
      fill_q   = 0;
      msg_bits = '0;
   endfunction

   // absorb one request word, queue the digest on the final word
   task automatic absorb_word(word_type w, int nb, logic fin);
      word_type mask;
      digest_item_type it;
      if (!fin) begin
         msg_bits += 64'd32;
         push_block_word(w);
         return;
      end
      if (nb > 4) nb = 4;
      msg_bits += 64'(nb * 8);
      if (nb == 4) begin
         push_block_word(w);
         push_block_word(PAD_WORD);
      end else begin
         mask = (nb == 0) ? '0 : ('1 << (32 - 8 * nb));
         push_block_word((w & mask) | (word_type'(PAD_BYTE) << (24 - 8 * nb)));
      end
      if (fill_q > 14) while (fill_q != 0) push_block_word('0);
      while (fill_q < 14) push_block_word('0);
      push_block_word(msg_bits[63:32]);
      push_block_word(msg_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         it.dword = chain_q[i];
         it.index = 3'(i);
         it.last  = (i == 7);
         digest_fifo.push_back(it);
      end
      rearm();
   endtask

   // watch both channels on every rising edge
   always @(posedge clock) begin
      digest_item_type exp_it;
      if (reset) begin
         rearm();
         digest_fifo.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_fifo.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected digest word %h idx %0d", rsp_tdata[31:0],
                           rsp_tdata[34:32]);
               fail_count <= fail_count + 1;
            end else begin
               exp_it = digest_fifo.pop_front();
               if (rsp_tdata[31:0] !== exp_it.dword || rsp_tdata[34:32] !== exp_it.index
                   || rsp_tlast !== exp_it.last) begin
                  if (fail_count < 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              exp_it.dword, exp_it.index, exp_it.last,
                              rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_word(req_tdata[31:0], int'(req_tdata[34:32]), req_tlast);
      end
   end

endmodule

// ===== tb/tb_sm3_hash_engine.sv =====
// testbench top for sm3_hash_engine: message stimulus, idling and verdict
// depends on sm3_pkg, sm3_hash_engine and sm3_hash_checker
`timescale 1ns / 100ps

module tb_sm3_hash_engine;
   import sm3_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          burst_left = 0;

   sm3_hash_engine i_dut (.*);

   sm3_hash_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall pattern: long ready stretches alternating with random stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (cycle_count[11]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // send one word, idling between bursts
   task automatic send_word(logic [31:0] w, logic [2:0] nb, logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nb, w};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // a message of n full words followed by a final word with nb bytes
   task automatic send_message(int n, logic [2:0] nb);
      for (int i = 0; i < n; i++)
         send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
      send_word($urandom, nb, 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, field extremes, oversized byte count, padding splits
      send_word(32'hFFFFFFFF, 3'd0, 1'b1);
      send_word(32'h61626300, 3'd3, 1'b1);
      send_word(32'hFFFFFFFF, 3'd7, 1'b1);
      send_word(32'h00000000, 3'd4, 1'b1);
      send_word(32'hA5A5A5A5, 3'd1, 1'b1);
      send_message(13, 3'd4);
      send_word(32'h12345678, 3'd2, 1'b1);

      // hold off until all digests are back
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // random messages, mostly short, a few spanning blocks
      for (int k = 0; k < 14; k++)
         send_message(($urandom_range(0, 4) == 0) ? $urandom_range(12, 20)
                      : $urandom_range(0, 5), 3'($urandom_range(0, 7)));
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sm3_pkg.sv
sv/sm3_hash_engine.sv
tb/sm3_hash_checker.sv
tb/tb_sm3_hash_engine.sv
